// ----- hdl/jsi_pkg.sv -----
// ----------------------------------------------------------------------------
// jsi_pkg
// shared constants, result types and helpers of the json stream indenter
// ----------------------------------------------------------------------------
package jsi_pkg;

    // nesting limit and counter width
    localparam int DEPTH_W   = 7;
    localparam int MAX_DEPTH = 64;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_V = DEPTH_W'(MAX_DEPTH);

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int WIDTH_W = 5;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 5'd4;
    localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = 5'd16;
    localparam logic [0:0] REG_INDENT_WIDTH = 1'b0;

    localparam int SPACE_W = 11;
    localparam int MAX_RESULTS = 4;
    localparam int COUNT_W = 3;

    // result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_OK   = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [7:0]         out_byte;
        logic [SPACE_W-1:0] space_count;
        logic               run_end;
    } result_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [COUNT_W-1:0]            count;
        result_t [MAX_RESULTS-1:0]     items;
    } batch_t;

    function automatic result_t make_char(input logic [7:0] ch);
        result_t r;
        r = '0;
        r.result_kind = KIND_CHAR;
        r.out_byte = ch;
        return r;
    endfunction

    function automatic result_t make_line(input logic [SPACE_W-1:0] sp);
        result_t r;
        r = '0;
        r.result_kind = KIND_LINE;
        r.space_count = sp;
        return r;
    endfunction

    function automatic result_t make_status(input logic [1:0] kind);
        result_t r;
        r = '0;
        r.result_kind = kind;
        return r;
    endfunction

endpackage

// ----- hdl/jsi_if.sv -----
// ----------------------------------------------------------------------------
// jsi_if
// valid/ready stream interfaces for text bytes in and results out
// ----------------------------------------------------------------------------
interface jsi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jsi_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  out_byte;
    logic [10:0] space_count;
    logic        run_end;

    modport source (
        output valid, output result_kind, output out_byte, output space_count,
        output run_end, input ready
    );
    modport sink (
        input valid, input result_kind, input out_byte, input space_count,
        input run_end, output ready
    );
endinterface

// ----- hdl/jsi_cfg.sv -----
// ----------------------------------------------------------------------------
// jsi_cfg
// apb register slave holding the indent width
// ----------------------------------------------------------------------------
module jsi_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jsi_pkg::ADDR_W-1:0]  paddr,
    input  logic [jsi_pkg::DATA_W-1:0]  pwdata,
    output logic [jsi_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [jsi_pkg::WIDTH_W-1:0] indent_width
);
    import jsi_pkg::*;

    logic [WIDTH_W-1:0] width_reg;
    logic               hit;

    assign hit = (paddr[ADDR_W-1] == REG_INDENT_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            width_reg <= pwdata[WIDTH_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = hit ? {{(DATA_W-WIDTH_W){1'b0}}, width_reg} : '0;
    assign indent_width = width_reg;

endmodule

// ----- hdl/jsi_formatter.sv -----
// ----------------------------------------------------------------------------
// jsi_formatter
// input register, parser state and per-byte result generation
// ----------------------------------------------------------------------------
module jsi_formatter (
    input  logic                        clk,
    input  logic                        rst_n,
    jsi_in_if.sink                      in_ch,
    input  logic [jsi_pkg::WIDTH_W-1:0] indent_width,
    output jsi_pkg::batch_t             batch,
    output logic                        batch_valid,
    input  logic                        batch_ready
);
    import jsi_pkg::*;

    logic       hold_valid_reg;
    logic [7:0] hold_byte_reg;
    logic       hold_eot_reg;

    logic               awaiting_reg, awaiting_next;
    logic               in_string_reg, in_string_next;
    logic [7:0]         prev_reg, prev_next;
    logic [DEPTH_W-1:0] level_reg, level_next;
    logic [DEPTH_W-1:0] nest_reg, nest_next;
    logic [DEPTH_W-1:0] list_reg, list_next;
    logic               failed_reg, failed_next;

    logic                   accept_in;
    logic                   advance;
    logic [WIDTH_W-1:0]     w;
    logic [SPACE_W:0]       prod;
    logic [SPACE_W-1:0]     base_sp, up_sp, dn_sp;
    logic                   outside;
    logic                   err;
    logic [COUNT_W-1:0]     n;
    result_t [MAX_RESULTS-1:0] res;
    logic [7:0]             b;
    logic                   eot;

    assign in_ch.ready = !hold_valid_reg || batch_ready;
    assign accept_in   = in_ch.valid && in_ch.ready;
    assign advance     = hold_valid_reg && batch_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept_in)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            hold_byte_reg <= in_ch.text_byte;
            hold_eot_reg  <= in_ch.end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b1;
            in_string_reg <= 1'b0;
            prev_reg      <= '0;
            level_reg     <= DEPTH_W'(1);
            nest_reg      <= DEPTH_W'(1);
            list_reg      <= '0;
            failed_reg    <= 1'b0;
        end
        else if (advance)
        begin
            awaiting_reg  <= awaiting_next;
            in_string_reg <= in_string_next;
            prev_reg      <= prev_next;
            level_reg     <= level_next;
            nest_reg      <= nest_next;
            list_reg      <= list_next;
            failed_reg    <= failed_next;
        end
    end

    // indent spaces at the current level and one level up or down
    assign w       = (indent_width > WIDTH_LIMIT) ? WIDTH_LIMIT : indent_width;
    assign prod    = (SPACE_W+1)'(w) * (SPACE_W+1)'(level_reg);
    assign base_sp = prod[SPACE_W-1:0];
    assign up_sp   = base_sp + SPACE_W'(w);
    assign dn_sp   = base_sp - SPACE_W'(w);

    assign b       = hold_byte_reg;
    assign eot     = hold_eot_reg;
    assign outside = !in_string_reg;

    always_comb
    begin
        awaiting_next  = awaiting_reg;
        in_string_next = in_string_reg;
        prev_next      = prev_reg;
        level_next     = level_reg;
        nest_next      = nest_reg;
        list_next      = list_reg;
        failed_next    = failed_reg;
        err            = 1'b0;
        n              = '0;
        res            = '0;

        if (failed_reg)
        begin
            if (eot)
            begin
                awaiting_next  = 1'b1;
                in_string_next = 1'b0;
                prev_next      = '0;
                level_next     = DEPTH_W'(1);
                nest_next      = DEPTH_W'(1);
                list_next      = '0;
                failed_next    = 1'b0;
            end
            else
            begin
                prev_next = b;
            end
        end
        else
        begin
            if (awaiting_reg)
            begin
                awaiting_next = 1'b0;
                res[0] = make_char(b);
                res[1] = make_line(SPACE_W'(w));
                n = 3'd2;
            end
            else if (b == CH_QUOTE)
            begin
                if (prev_reg != CH_BSLASH)
                begin
                    in_string_next = !in_string_reg;
                end
                res[0] = make_char(b);
                n = 3'd1;
            end
            else if (b == CH_SPACE && outside)
            begin
                n = 3'd0;
            end
            else if (b == CH_LBRACE && outside && list_reg == '0)
            begin
                if (nest_reg >= MAX_DEPTH_V)
                begin
                    err = 1'b1;
                end
                else
                begin
                    nest_next  = nest_reg + DEPTH_W'(1);
                    level_next = level_reg + DEPTH_W'(1);
                    res[0] = make_line(base_sp);
                    res[1] = make_char(b);
                    res[2] = make_line(up_sp);
                    n = 3'd3;
                end
            end
            else if (b == CH_RBRACE && outside && list_reg == '0)
            begin
                if (level_reg == '0)
                begin
                    err = 1'b1;
                end
                else
                begin
                    nest_next  = nest_reg - DEPTH_W'(1);
                    level_next = level_reg - DEPTH_W'(1);
                    res[0] = make_line(dn_sp);
                    res[1] = make_char(b);
                    n = 3'd2;
                end
            end
            else if (b == CH_LBRACK && outside)
            begin
                if (nest_reg >= MAX_DEPTH_V)
                begin
                    err = 1'b1;
                end
                else
                begin
                    list_next = list_reg + DEPTH_W'(1);
                    nest_next = nest_reg + DEPTH_W'(1);
                    res[0] = make_char(b);
                    n = 3'd1;
                end
            end
            else if (b == CH_RBRACK && outside)
            begin
                if (list_reg == '0 || nest_reg == '0)
                begin
                    err = 1'b1;
                end
                else
                begin
                    list_next = list_reg - DEPTH_W'(1);
                    nest_next = nest_reg - DEPTH_W'(1);
                    res[0] = make_char(b);
                    n = 3'd1;
                end
            end
            else if (b == CH_COMMA && outside)
            begin
                res[0] = make_char(b);
                res[1] = make_char(CH_SPACE);
                if (list_reg == '0)
                begin
                    res[2] = make_line(base_sp);
                    n = 3'd3;
                end
                else
                begin
                    n = 3'd2;
                end
            end
            else if (b == CH_COLON && outside)
            begin
                res[0] = make_char(b);
                res[1] = make_char(CH_SPACE);
                n = 3'd2;
            end
            else
            begin
                res[0] = make_char(b);
                n = 3'd1;
            end

            prev_next = b;

            if (err)
            begin
                res = '0;
                res[0] = make_status(KIND_ERR);
                n = 3'd1;
                failed_next = 1'b1;
            end
            else if (eot)
            begin
                // closing status after the byte's own results
                res[n[1:0]] = make_status((nest_next == '0 && list_next == '0) ?
                                          KIND_OK : KIND_ERR);
                n = n + 3'd1;
            end

            if (eot)
            begin
                awaiting_next  = 1'b1;
                in_string_next = 1'b0;
                prev_next      = '0;
                level_next     = DEPTH_W'(1);
                nest_next      = DEPTH_W'(1);
                list_next      = '0;
                failed_next    = 1'b0;
            end
        end

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i].run_end = (COUNT_W'(i) == n - 3'd1);
        end
    end

    assign batch_valid = hold_valid_reg;
    assign batch.count = n;
    assign batch.items = res;

endmodule

// ----- hdl/jsi_emitter.sv -----
// ----------------------------------------------------------------------------
// jsi_emitter
// result buffer that hands out the results of one byte one per transaction
// ----------------------------------------------------------------------------
module jsi_emitter (
    input  logic            clk,
    input  logic            rst_n,
    input  jsi_pkg::batch_t batch,
    input  logic            batch_valid,
    output logic            batch_ready,
    jsi_out_if.source       out_ch
);
    import jsi_pkg::*;

    result_t    res_reg [MAX_RESULTS];
    logic       busy_reg;
    logic [1:0] idx_reg;
    result_t    cur;
    logic       load;
    logic       fire;

    assign cur         = res_reg[idx_reg];
    assign fire        = out_ch.valid && out_ch.ready;
    assign batch_ready = !busy_reg || (fire && cur.run_end);
    assign load        = batch_valid && batch_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= (batch.count != '0);
            idx_reg  <= '0;
        end
        else if (fire)
        begin
            busy_reg <= !cur.run_end;
            idx_reg  <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                res_reg[i] <= batch.items[i];
            end
        end
    end

    assign out_ch.valid       = busy_reg;
    assign out_ch.result_kind = cur.result_kind;
    assign out_ch.out_byte    = cur.out_byte;
    assign out_ch.space_count = cur.space_count;
    assign out_ch.run_end     = cur.run_end;

endmodule

// ----- hdl/json_stream_indenter.sv -----
// ----------------------------------------------------------------------------
// json_stream_indenter
// path: a byte is held in the input register, then its results load into the
//   result buffer once it is free, which offers them on the output port
// throughput: one byte per cycle when each gives at most one result and the
//   output takes every result; a byte giving several results holds the input
//   until the result buffer has handed out its last one
// reset: asynchronous active low; parser state and indent width to defaults
// ----------------------------------------------------------------------------
module json_stream_indenter (
    input  logic                        clk,
    input  logic                        rst_n,
    jsi_in_if.sink                      in_ch,
    jsi_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jsi_pkg::ADDR_W-1:0]  paddr,
    input  logic [jsi_pkg::DATA_W-1:0]  pwdata,
    output logic [jsi_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import jsi_pkg::*;

    // indent width from the register slave, clamped inside the formatter
    logic [WIDTH_W-1:0] indent_width;

    // batch of up to four results for the byte in the input register
    batch_t batch;
    logic   batch_valid;
    logic   batch_ready;

    jsi_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .indent_width (indent_width)
    );

    // input register plus parser: state moves on when the buffer takes the batch
    jsi_formatter u_formatter (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .indent_width (indent_width),
        .batch        (batch),
        .batch_valid  (batch_valid),
        .batch_ready  (batch_ready)
    );

    // result buffer: frees on the last result's transaction, so the next
    // batch loads in the same cycle and single results stream back to back
    jsi_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .batch        (batch),
        .batch_valid  (batch_valid),
        .batch_ready  (batch_ready),
        .out_ch       (out_ch)
    );

endmodule

// ----- dv/tb_json_stream_indenter.sv -----
// ----------------------------------------------------------------------------
// tb_json_stream_indenter
// streams compact json texts through the indenter, predicts every result of
// each accepted byte in a local model and compares the output transactions
// field by field, over several indent widths and idling patterns
// ----------------------------------------------------------------------------
module tb_json_stream_indenter;
    timeunit 1ns;
    timeprecision 1ps;

    import jsi_pkg::*;

    typedef logic [7:0] bytes_t[$];

    // one input transaction: a character and the end-of-text mark
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    localparam int NUM_PHASES    = 8;
    localparam int PHASE_BYTES   = 24;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_SHOWN     = 10;

    // punctuation the parser acts on, plus a newline, mixed into strings
    localparam logic [7:0] JSON_PUNCT [8] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                                              CH_COMMA, CH_COLON, CH_SPACE, CH_NEWLINE};

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    jsi_in_if  in_ch();
    jsi_out_if out_ch();

    json_stream_indenter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // formatter state mirrored by the testbench
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0] indent_width;
    logic               awaiting_first;
    logic               in_string;
    logic               parse_failed;
    logic [7:0]         prev_ch;
    int                 indent_level;
    int                 nest_depth;
    int                 list_depth;

    text_beat_t  text_q[$];        // bytes waiting to be sent
    result_t     formatted_q[$];   // results the block still owes us
    idle_mode_e  idle_mode;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;

    function automatic void restart_parser();
        awaiting_first = 1'b1;
        in_string      = 1'b0;
        prev_ch        = 8'h00;
        indent_level   = 1;
        nest_depth     = 1;
        list_depth     = 0;
        parse_failed   = 1'b0;
    endfunction

    // widths above the limit are clipped
    function automatic logic [SPACE_W-1:0] indent_spaces(input int lvl);
        int w;
        w = (indent_width > WIDTH_LIMIT) ? int'(WIDTH_LIMIT) : int'(indent_width);
        return SPACE_W'(w * lvl);
    endfunction

    function automatic result_t result_of(input logic [1:0] kind, input logic [7:0] ch,
                                          input logic [SPACE_W-1:0] sp);
        result_t r;
        r.result_kind = kind;
        r.out_byte    = ch;
        r.space_count = sp;
        r.run_end     = 1'b0;
        return r;
    endfunction

    // works out the results of one accepted byte and queues them
    function automatic void format_byte(input logic [7:0] ch, input logic last);
        result_t run[$];
        logic    outside;
        logic    bad;
        bad = 1'b0;
        // after an error everything is swallowed until the end of the text
        if (parse_failed)
        begin
            if (last)
                restart_parser();
            else
                prev_ch = ch;
            return;
        end
        if (awaiting_first)
        begin
            // first byte is copied unparsed, then one indent
            awaiting_first = 1'b0;
            run.push_back(result_of(KIND_CHAR, ch, '0));
            run.push_back(result_of(KIND_LINE, 8'h00, indent_spaces(1)));
        end
        else
        begin
            outside = !in_string;
            if (ch == CH_QUOTE)
            begin
                // escaped quote leaves the string state alone
                if (prev_ch != CH_BSLASH)
                    in_string = !in_string;
                run.push_back(result_of(KIND_CHAR, ch, '0));
            end
            else if (ch == CH_SPACE && outside)
            begin
                // blank between tokens is dropped
            end
            else if (ch == CH_LBRACE && outside && list_depth == 0)
            begin
                if (nest_depth >= MAX_DEPTH)
                    bad = 1'b1;
                else
                begin
                    nest_depth++;
                    run.push_back(result_of(KIND_LINE, 8'h00, indent_spaces(indent_level)));
                    run.push_back(result_of(KIND_CHAR, ch, '0));
                    indent_level++;
                    run.push_back(result_of(KIND_LINE, 8'h00, indent_spaces(indent_level)));
                end
            end
            else if (ch == CH_RBRACE && outside && list_depth == 0)
            begin
                if (indent_level == 0)
                    bad = 1'b1;
                else
                begin
                    nest_depth--;
                    indent_level--;
                    run.push_back(result_of(KIND_LINE, 8'h00, indent_spaces(indent_level)));
                    run.push_back(result_of(KIND_CHAR, ch, '0));
                end
            end
            else if (ch == CH_LBRACK && outside)
            begin
                if (nest_depth >= MAX_DEPTH)
                    bad = 1'b1;
                else
                begin
                    list_depth++;
                    nest_depth++;
                    run.push_back(result_of(KIND_CHAR, ch, '0));
                end
            end
            else if (ch == CH_RBRACK && outside)
            begin
                if (list_depth == 0 || nest_depth == 0)
                    bad = 1'b1;
                else
                begin
                    list_depth--;
                    nest_depth--;
                    run.push_back(result_of(KIND_CHAR, ch, '0));
                end
            end
            else if (ch == CH_COMMA && outside)
            begin
                run.push_back(result_of(KIND_CHAR, ch, '0));
                run.push_back(result_of(KIND_CHAR, CH_SPACE, '0));
                if (list_depth == 0)
                    run.push_back(result_of(KIND_LINE, 8'h00, indent_spaces(indent_level)));
            end
            else if (ch == CH_COLON && outside)
            begin
                run.push_back(result_of(KIND_CHAR, ch, '0));
                run.push_back(result_of(KIND_CHAR, CH_SPACE, '0));
            end
            else
                run.push_back(result_of(KIND_CHAR, ch, '0));
        end
        prev_ch = ch;

        if (bad)
        begin
            // the error replaces anything this byte produced
            run.delete();
            run.push_back(result_of(KIND_ERR, 8'h00, '0));
            parse_failed = 1'b1;
            if (last)
                restart_parser();
        end
        else if (last)
        begin
            run.push_back(result_of((nest_depth == 0 && list_depth == 0) ? KIND_OK : KIND_ERR,
                                    8'h00, '0));
            restart_parser();
        end

        if (run.size() > 0)
            run[run.size()-1].run_end = 1'b1;
        foreach (run[i])
            formatted_q.push_back(run[i]);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_text(input bytes_t t);
        text_beat_t beat;
        foreach (t[i])
        begin
            beat.ch   = t[i];
            beat.last = (i == t.size() - 1);
            text_q.push_back(beat);
        end
    endfunction

    function automatic bytes_t text_of(input string s);
        bytes_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s.getc(i));
        return t;
    endfunction

    // mostly well-formed objects with random content, some garbage and damage
    function automatic bytes_t random_text();
        bytes_t t;
        int     open_kind[$];   // 0 object, 1 list
        int     members[$];
        int     budget;
        int     pick;
        int     pos;
        logic [7:0] c;
        budget = $urandom_range(30, 6);
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            // a lone byte: never parsed, always ends in error
            t.push_back(8'($urandom));
            return t;
        end
        if (pick < 14)
        begin
            repeat ($urandom_range(8, 2))
                t.push_back(8'($urandom));
            return t;
        end

        // the opening brace is the copied first byte
        t.push_back(CH_LBRACE);
        open_kind.push_back(0);
        members.push_back(0);
        while (open_kind.size() > 0)
        begin
            if (t.size() >= budget || (members[members.size()-1] > 0 && $urandom_range(2) == 0))
            begin
                t.push_back(open_kind[open_kind.size()-1] != 0 ? CH_RBRACK : CH_RBRACE);
                void'(open_kind.pop_back());
                void'(members.pop_back());
            end
            else
            begin
                if (members[members.size()-1] > 0)
                    t.push_back(CH_COMMA);
                members[members.size()-1] += 1;
                if (open_kind[open_kind.size()-1] == 0)
                begin
                    t.push_back(CH_QUOTE);
                    t.push_back(8'h61 + 8'($urandom_range(25)));
                    t.push_back(CH_QUOTE);
                    t.push_back(CH_COLON);
                end
                if ($urandom_range(4) == 0)
                    t.push_back(CH_SPACE);
                pick = $urandom_range(9);
                if (pick < 3 && open_kind.size() < 5)
                begin
                    t.push_back(pick == 0 ? CH_LBRACK : CH_LBRACE);
                    open_kind.push_back(pick == 0 ? 1 : 0);
                    members.push_back(0);
                end
                else if (pick < 7)
                begin
                    // string body: any byte, punctuation and escapes
                    t.push_back(CH_QUOTE);
                    repeat ($urandom_range(4))
                    begin
                        c = ($urandom_range(1) == 0) ? 8'($urandom) : JSON_PUNCT[$urandom_range(7)];
                        if (c == CH_QUOTE)
                            t.push_back(CH_BSLASH);
                        t.push_back(c);
                        if (c == CH_BSLASH)
                            t.push_back(8'h6E);
                    end
                    t.push_back(CH_QUOTE);
                end
                else
                begin
                    repeat ($urandom_range(3, 1))
                        t.push_back(8'h30 + 8'($urandom_range(9)));
                end
            end
        end

        // damage a share of the texts
        if ($urandom_range(99) < 20)
        begin
            pos = $urandom_range(t.size() - 1);
            case ($urandom_range(2))
                0: t[pos] = 8'($urandom);
                1: t = t[0:pos];
                default: t.insert(pos, $urandom_range(1) ? CH_RBRACE : CH_RBRACK);
            endcase
        end
        return t;
    endfunction

    function automatic bit draw_idle(input bit receiver);
        case (idle_mode)
            IDLE_SEND: return !receiver && $urandom_range(99) < 47;
            IDLE_RECV: return receiver && $urandom_range(99) < 47;
            IDLE_BOTH: return $urandom_range(99) < 8;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic void report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("mismatch: %s", what);
    endfunction

    // block is idle: nothing queued, nothing in flight, trailing bytes settled
    task automatic wait_idle();
        while (text_q.size() > 0 || in_ch.valid || formatted_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup cycle, then access cycle; the register takes the value on pready
    task automatic write_indent_width(input int w);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(REG_INDENT_WIDTH));
        pwdata  <= DATA_W'(w);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        indent_width = WIDTH_W'(w);
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // driver: feeds text bytes, predicts on every accepted transaction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        text_beat_t beat;
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.text_byte   <= 8'h00;
            in_ch.end_of_text <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                format_byte(in_ch.text_byte, in_ch.end_of_text);
            // a held byte stays put until it is taken
            if (!in_ch.valid || in_ch.ready)
            begin
                if (text_q.size() > 0 && !draw_idle(1'b0))
                begin
                    beat = text_q.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.text_byte   <= beat.ch;
                    in_ch.end_of_text <= beat.last;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (formatted_q.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d byte %02h spaces %0d end %0d",
                                              out_ch.result_kind, out_ch.out_byte,
                                              out_ch.space_count, out_ch.run_end));
                else
                begin
                    want = formatted_q.pop_front();
                    if (out_ch.result_kind !== want.result_kind || out_ch.out_byte !== want.out_byte
                        || out_ch.space_count !== want.space_count
                        || out_ch.run_end !== want.run_end)
                        report_mismatch($sformatf(
                            "kind %0d/%0d byte %02h/%02h spaces %0d/%0d end %0d/%0d (exp/act)",
                            want.result_kind, out_ch.result_kind, want.out_byte, out_ch.out_byte,
                            want.space_count, out_ch.space_count, want.run_end, out_ch.run_end));
                end
            end
            out_ch.ready <= !draw_idle(1'b1);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction ends the run
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("json_stream_indenter test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int     widths[NUM_PHASES];
        int     sent;
        bytes_t t;

        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.text_byte   = 8'h00;
        in_ch.end_of_text = 1'b0;
        out_ch.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        indent_width      = WIDTH_RESET;
        idle_mode         = IDLE_NONE;
        restart_parser();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // zero, the clip limit and the widest code are all visited
        widths = '{4, 0, 16, 31, 1, 0, 9, 16};
        widths[5] = $urandom_range(31);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_indent_width(widths[p]);
            idle_mode = idle_mode_e'(p % 4);
            sent = 0;

            if (p == 0)
            begin
                // single-byte text ends in error
                push_text(text_of("A"));
                // close brace at level zero, then bytes swallowed until the end
                push_text(text_of("x}}ab"));
                // list underflow
                push_text(text_of("x]"));
                // escaped quote, blanks in and out of strings, list and object commas
                push_text(text_of("{\"\\\" b\": [1,\"]\"],\"\":{}}"));
                // end mark on a dropped blank
                push_text(text_of("{} "));
                // open brace with the end mark: the most results one byte can give
                push_text(text_of("x{"));
                sent = 36;
            end
            else if (p == 2)
            begin
                // objects nested to the limit (widest indent), then one too many
                t = text_of("{");
                repeat (MAX_DEPTH) t.push_back(CH_LBRACE);
                t.push_back(8'h61);
                t.push_back(CH_RBRACE);
                push_text(t);
                sent = t.size();
            end
            else if (p == 5)
            begin
                // lists nested past the limit
                t = text_of("{");
                repeat (MAX_DEPTH) t.push_back(CH_LBRACK);
                t.push_back(CH_RBRACK);
                push_text(t);
                sent = t.size();
            end

            while (sent < PHASE_BYTES)
            begin
                t = random_text();
                push_text(t);
                sent += t.size();
            end
        end

        wait_idle();
        if (mismatch_count == 0 && formatted_q.size() == 0)
            $display("json_stream_indenter test passed");
        else
            $display("json_stream_indenter test failed");
        $finish;
    end

endmodule
